[rtl/bcc_pkg.sv]
`timescale 1ns / 1ps
package bcc_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_ENTRIES  = 512;

  localparam int VCOUNT_W = 7;
  localparam int VID_W    = 6;
  localparam int COMP_W   = 8;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_APP_WR,
    ST_APP_LINK,
    ST_SRCH_INIT,
    ST_ROOT,
    ST_OPEN,
    ST_EDGE,
    ST_NBR,
    ST_BACK,
    ST_POP_RET,
    ST_CMP_RD,
    ST_CMP_A,
    ST_CMP_B,
    ST_CMP_FIN,
    ST_FETCH,
    ST_FETCH_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_TAKE,
    OP_APP_WR,
    OP_APP_LINK,
    OP_SRCH_INIT,
    OP_ROOT,
    OP_OPEN,
    OP_EDGE,
    OP_NBR,
    OP_BACK,
    OP_POP_RET,
    OP_CMP_RD,
    OP_CMP_A,
    OP_CMP_B,
    OP_CMP_FIN,
    OP_FETCH,
    OP_FETCH_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_func;
    logic out_busy;
    logic out_phase;
    logic app_ok;
    logic root_done;
    logic root_visited;
    logic edge_none;
    logic sp_last;
    logic nbr_skip;
    logic nbr_visited;
    logic pop_comp;
    logic stack_empty;
    logic cmp_stop;
    logic res_empty;
  } stat_t;

endpackage

[rtl/bcc_in_if.sv]
`timescale 1ns / 1ps
interface bcc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [bcc_pkg::VID_W-1:0]  from_vertex;
  logic [bcc_pkg::VID_W-1:0]  to_vertex;

  modport source (output valid, func, from_vertex, to_vertex, input ready);
  modport sink   (input valid, func, from_vertex, to_vertex, output ready);
endinterface

[rtl/bcc_out_if.sv]
`timescale 1ns / 1ps
interface bcc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        has_pair;
  logic [bcc_pkg::COMP_W-1:0]  component_index;
  logic [bcc_pkg::VID_W-1:0]   member_vertex;
  logic                        last_in_component;
  logic                        last_overall;
  logic                        overflow;

  modport source (output valid, has_pair, component_index, member_vertex,
                  last_in_component, last_overall, overflow, input ready);
  modport sink   (input valid, has_pair, component_index, member_vertex,
                  last_in_component, last_overall, overflow, output ready);
endinterface

[rtl/biconnected_components_unit.sv]
`timescale 1ns / 1ps
// append request: take, store entry, link list; a dropped entry skips the link step
// fetch request: result registered in the fetch state when no pairs remain, else in the fetch-out state
// first fetch also runs the search, which steps through each vertex, list entry and popped
//   edge in turn over the single-port list and stack memories
// one request in flight at a time; a pending result holds off the next request
// reset (synchronous, active low): lists empty, flags clear, vertex_count 64, no clear pass
module biconnected_components_unit #(
  parameter int MAX_VERTICES = bcc_pkg::DEF_MAX_VERTICES,
  parameter int MAX_ENTRIES  = bcc_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::VCOUNT_W-1:0]  cfg_wdata,
  bcc_in_if.sink                        in_chan,
  bcc_out_if.source                     out_chan
);

  bcc_pkg::cmd_t  cmd;
  bcc_pkg::stat_t st;

  bcc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  bcc_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_ENTRIES  (MAX_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

[rtl/bcc_ctrl.sv]
`timescale 1ns / 1ps
module bcc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  bcc_pkg::stat_t st,
  output bcc_pkg::cmd_t  cmd
);

  bcc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcc_pkg::ST_IDLE: begin
        if (st.in_fire) begin
          if (st.in_func) begin
            state_nxt = st.out_phase ? bcc_pkg::ST_FETCH : bcc_pkg::ST_SRCH_INIT;
          end else begin
            // appends are ignored while results are pending
            state_nxt = st.out_phase ? bcc_pkg::ST_IDLE : bcc_pkg::ST_APP_WR;
          end
        end
      end
      bcc_pkg::ST_APP_WR:    state_nxt = st.app_ok ? bcc_pkg::ST_APP_LINK : bcc_pkg::ST_IDLE;
      bcc_pkg::ST_APP_LINK:  state_nxt = bcc_pkg::ST_IDLE;
      bcc_pkg::ST_SRCH_INIT: state_nxt = bcc_pkg::ST_ROOT;
      bcc_pkg::ST_ROOT: begin
        priority if (st.root_done) begin
          state_nxt = bcc_pkg::ST_FETCH;
        end else if (st.root_visited) begin
          state_nxt = bcc_pkg::ST_ROOT;
        end else begin
          state_nxt = bcc_pkg::ST_OPEN;
        end
      end
      bcc_pkg::ST_OPEN: state_nxt = bcc_pkg::ST_EDGE;
      bcc_pkg::ST_EDGE: begin
        priority if (!st.edge_none) begin
          state_nxt = bcc_pkg::ST_NBR;
        end else if (st.sp_last) begin
          state_nxt = bcc_pkg::ST_ROOT;
        end else begin
          state_nxt = bcc_pkg::ST_POP_RET;
        end
      end
      bcc_pkg::ST_NBR: begin
        priority if (st.nbr_skip) begin
          state_nxt = bcc_pkg::ST_EDGE;
        end else if (st.nbr_visited) begin
          state_nxt = bcc_pkg::ST_BACK;
        end else begin
          state_nxt = bcc_pkg::ST_OPEN;
        end
      end
      bcc_pkg::ST_BACK:    state_nxt = bcc_pkg::ST_EDGE;
      bcc_pkg::ST_POP_RET: state_nxt = st.pop_comp ? bcc_pkg::ST_CMP_RD : bcc_pkg::ST_EDGE;
      bcc_pkg::ST_CMP_RD:  state_nxt = st.stack_empty ? bcc_pkg::ST_CMP_FIN : bcc_pkg::ST_CMP_A;
      bcc_pkg::ST_CMP_A:   state_nxt = bcc_pkg::ST_CMP_B;
      bcc_pkg::ST_CMP_B:   state_nxt = st.cmp_stop ? bcc_pkg::ST_CMP_FIN : bcc_pkg::ST_CMP_RD;
      bcc_pkg::ST_CMP_FIN: state_nxt = bcc_pkg::ST_EDGE;
      bcc_pkg::ST_FETCH:   state_nxt = st.res_empty ? bcc_pkg::ST_IDLE : bcc_pkg::ST_FETCH_OUT;
      bcc_pkg::ST_FETCH_OUT: state_nxt = bcc_pkg::ST_IDLE;
      default:             state_nxt = bcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = bcc_pkg::OP_TAKE;
    unique case (state_r)
      bcc_pkg::ST_IDLE: begin
        cmd.op       = bcc_pkg::OP_TAKE;
        cmd.in_ready = !st.out_busy;
      end
      bcc_pkg::ST_APP_WR:    cmd.op = bcc_pkg::OP_APP_WR;
      bcc_pkg::ST_APP_LINK:  cmd.op = bcc_pkg::OP_APP_LINK;
      bcc_pkg::ST_SRCH_INIT: cmd.op = bcc_pkg::OP_SRCH_INIT;
      bcc_pkg::ST_ROOT:      cmd.op = bcc_pkg::OP_ROOT;
      bcc_pkg::ST_OPEN:      cmd.op = bcc_pkg::OP_OPEN;
      bcc_pkg::ST_EDGE:      cmd.op = bcc_pkg::OP_EDGE;
      bcc_pkg::ST_NBR:       cmd.op = bcc_pkg::OP_NBR;
      bcc_pkg::ST_BACK:      cmd.op = bcc_pkg::OP_BACK;
      bcc_pkg::ST_POP_RET:   cmd.op = bcc_pkg::OP_POP_RET;
      bcc_pkg::ST_CMP_RD:    cmd.op = bcc_pkg::OP_CMP_RD;
      bcc_pkg::ST_CMP_A:     cmd.op = bcc_pkg::OP_CMP_A;
      bcc_pkg::ST_CMP_B:     cmd.op = bcc_pkg::OP_CMP_B;
      bcc_pkg::ST_CMP_FIN:   cmd.op = bcc_pkg::OP_CMP_FIN;
      bcc_pkg::ST_FETCH:     cmd.op = bcc_pkg::OP_FETCH;
      bcc_pkg::ST_FETCH_OUT: cmd.op = bcc_pkg::OP_FETCH_OUT;
      default:               cmd.op = bcc_pkg::OP_TAKE;
    endcase
  end

  // a pending result blocks new requests
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st.out_busy |-> !cmd.in_ready)
    else $error("request taken while result pending");

  a_search_ends_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcc_pkg::ST_ROOT && st.root_done) |=> state_r == bcc_pkg::ST_FETCH)
    else $error("search end did not lead to fetch");

  a_cmp_leaves_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcc_pkg::ST_CMP_FIN) |=> state_r == bcc_pkg::ST_EDGE)
    else $error("component pop did not resume search");

endmodule

[rtl/bcc_dpath.sv]
`timescale 1ns / 1ps
module bcc_dpath #(
  parameter int MAX_VERTICES = bcc_pkg::DEF_MAX_VERTICES,
  parameter int MAX_ENTRIES  = bcc_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::VCOUNT_W-1:0]  cfg_wdata,
  bcc_in_if.sink                        in_chan,
  bcc_out_if.source                     out_chan,
  input  bcc_pkg::cmd_t                 cmd,
  output bcc_pkg::stat_t                st
);

  localparam int MV  = MAX_VERTICES;
  localparam int ME  = MAX_ENTRIES;
  localparam int VW  = $clog2(MV);
  localparam int EW  = $clog2(ME);
  localparam int NW  = ($clog2(MV + 1) > bcc_pkg::VCOUNT_W) ? $clog2(MV + 1)
                                                              : bcc_pkg::VCOUNT_W;
  localparam int CW  = $clog2(ME + 1);
  localparam int SW  = $clog2(MV + 1);
  localparam int RD  = ME + MV;
  localparam int RW  = $clog2(RD);
  localparam int RCW = $clog2(RD + 1);
  localparam int LW  = EW + 1;
  localparam int FW  = 4 * VW + LW;
  localparam int XW  = bcc_pkg::COMP_W + VW + 1;
  localparam logic [LW-1:0] LNK_NONE = {1'b1, {EW{1'b0}}};

  // storage
  logic [VW-1:0] nbr_mem   [ME];
  logic [LW-1:0] link_mem  [ME];
  logic [EW-1:0] head_mem  [MV];
  logic [EW-1:0] tail_mem  [MV];
  logic [VW-1:0] disc_mem  [MV];
  logic [FW-1:0] frame_mem [MV];
  logic [2*VW-1:0] edge_mem [ME];
  logic [XW-1:0] res_mem   [RD];

  // control and search registers
  logic [bcc_pkg::VCOUNT_W-1:0] vcount_r;
  logic [CW-1:0]  cnt_r;
  logic           ovf_r;
  logic           phase_r;
  logic [MV-1:0]  head_vld_r;
  logic [MV-1:0]  visited_r;
  logic [MV-1:0]  seen_r;
  logic [bcc_pkg::VID_W-1:0] from_r, to_r;
  logic [NW-1:0]  n_r;
  logic [NW-1:0]  root_r;
  logic [VW-1:0]  timer_r;
  logic [CW-1:0]  etop_r;
  logic [RCW-1:0] rcnt_r, pos_r, start_r;
  logic [bcc_pkg::COMP_W-1:0] comp_r;
  logic [SW-1:0]  sp_r;
  logic [VW-1:0]  cu_r, cp_r, clow_r, cdisc_r;
  logic [LW-1:0]  ce_r;
  logic [VW-1:0]  v_r, par_r, child_r, chlow_r, cmp_u_r, cmp_c_r, lastv_r;

  // registered read data
  logic [EW-1:0]   head_q;
  logic            head_vq;
  logic [EW-1:0]   tail_q;
  logic [VW-1:0]   nbr_q;
  logic [LW-1:0]   link_q;
  logic [VW-1:0]   disc_q;
  logic [FW-1:0]   frame_q;
  logic [2*VW-1:0] edge_q;
  logic [XW-1:0]   res_q;

  // result register
  logic                        out_valid_r;
  logic                        o_has_r, o_lic_r, o_lov_r, o_ovf_r;
  logic [bcc_pkg::COMP_W-1:0]  o_comp_r;
  logic [bcc_pkg::VID_W-1:0]   o_vert_r;

  logic [NW-1:0]  n_cur, vc_ext;
  logic           in_fire, out_fire;
  logic [VW-1:0]  fv_idx;
  logic           app_ok;
  logic           nbr_skip;
  logic [VW-1:0]  f_v, f_p, f_low, f_disc;
  logic [LW-1:0]  f_next;
  logic [VW-1:0]  e_a, e_b, cmp_x;
  logic           add_ok;
  logic [RCW-1:0] rcnt_m1, pos_p1;
  logic [SW-1:0]  sp_m2;
  logic [VW-1:0]  head_addr;
  logic           fo_last;
  logic           push_edge;
  logic [VW-1:0]  push_to;
  logic           clear;

  assign vc_ext  = NW'(vcount_r);
  assign n_cur   = (vc_ext > NW'(MV)) ? NW'(MV) : vc_ext;
  assign in_fire = in_chan.valid && cmd.in_ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign fv_idx  = VW'(from_r);
  assign app_ok  = (cnt_r < CW'(ME)) && (NW'(from_r) < n_cur) && (NW'(to_r) < n_cur);
  assign nbr_skip = (NW'(nbr_q) >= n_r) || ((sp_r > SW'(1)) && (nbr_q == cp_r));

  assign f_disc = frame_q[VW-1:0];
  assign f_low  = frame_q[2*VW-1:VW];
  assign f_next = frame_q[2*VW+LW-1:2*VW];
  assign f_p    = frame_q[3*VW+LW-1:2*VW+LW];
  assign f_v    = frame_q[FW-1:3*VW+LW];
  assign e_a    = edge_q[2*VW-1:VW];
  assign e_b    = edge_q[VW-1:0];
  assign cmp_x  = (cmd.op == bcc_pkg::OP_CMP_A) ? e_a : e_b;
  assign add_ok = !seen_r[cmp_x] && (rcnt_r < RCW'(RD));
  assign rcnt_m1 = rcnt_r - RCW'(1);
  assign pos_p1  = pos_r + RCW'(1);
  assign sp_m2   = sp_r - SW'(2);
  assign head_addr = (cmd.op == bcc_pkg::OP_ROOT) ? root_r[VW-1:0] : nbr_q;
  assign fo_last = (pos_p1 == rcnt_r);

  always_comb begin
    push_edge = 1'b0;
    push_to   = nbr_q;
    if (cmd.op == bcc_pkg::OP_NBR && !nbr_skip && !visited_r[nbr_q]) begin
      push_edge = 1'b1;
    end
    if (cmd.op == bcc_pkg::OP_BACK && disc_q < cdisc_r) begin
      push_edge = 1'b1;
    end
    clear = (cmd.op == bcc_pkg::OP_FETCH && pos_r >= rcnt_r) ||
            (cmd.op == bcc_pkg::OP_FETCH_OUT && fo_last);
  end

  // status
  always_comb begin
    st.in_fire      = in_fire;
    st.in_func      = in_chan.func;
    st.out_busy     = out_valid_r;
    st.out_phase    = phase_r;
    st.app_ok       = app_ok;
    st.root_done    = root_r >= n_r;
    st.root_visited = visited_r[root_r[VW-1:0]];
    st.edge_none    = ce_r[EW];
    st.sp_last      = (sp_r == SW'(1));
    st.nbr_skip     = nbr_skip;
    st.nbr_visited  = visited_r[nbr_q];
    st.pop_comp     = chlow_r >= f_disc;
    st.stack_empty  = (etop_r == '0);
    st.cmp_stop     = (e_a == cmp_u_r) && (e_b == cmp_c_r);
    st.res_empty    = pos_r >= rcnt_r;
  end

  // adjacency memories
  always_ff @(posedge clk) begin
    if (cmd.op == bcc_pkg::OP_APP_WR && app_ok) begin
      nbr_mem[cnt_r[EW-1:0]] <= VW'(to_r);
    end
    if (cmd.op == bcc_pkg::OP_APP_WR && app_ok) begin
      link_mem[cnt_r[EW-1:0]] <= LNK_NONE;
    end else if (cmd.op == bcc_pkg::OP_APP_LINK && head_vld_r[fv_idx]) begin
      link_mem[tail_q] <= {1'b0, cnt_r[EW-1:0]};
    end
    if (cmd.op == bcc_pkg::OP_APP_LINK) begin
      tail_mem[fv_idx] <= cnt_r[EW-1:0];
      if (!head_vld_r[fv_idx]) begin
        head_mem[fv_idx] <= cnt_r[EW-1:0];
      end
    end
    if (cmd.op == bcc_pkg::OP_APP_WR) begin
      tail_q <= tail_mem[fv_idx];
    end
    if (cmd.op == bcc_pkg::OP_EDGE && !ce_r[EW]) begin
      nbr_q  <= nbr_mem[ce_r[EW-1:0]];
      link_q <= link_mem[ce_r[EW-1:0]];
    end
    if (cmd.op == bcc_pkg::OP_ROOT || cmd.op == bcc_pkg::OP_NBR) begin
      head_q  <= head_mem[head_addr];
      head_vq <= head_vld_r[head_addr];
    end
  end

  // search memories
  always_ff @(posedge clk) begin
    if (cmd.op == bcc_pkg::OP_OPEN) begin
      disc_mem[v_r] <= timer_r;
    end
    if (cmd.op == bcc_pkg::OP_NBR) begin
      disc_q <= disc_mem[nbr_q];
    end
    if (cmd.op == bcc_pkg::OP_NBR && !nbr_skip && !visited_r[nbr_q]) begin
      frame_mem[VW'(sp_r - SW'(1))] <= {cu_r, cp_r, link_q, clow_r, cdisc_r};
    end
    if (cmd.op == bcc_pkg::OP_EDGE) begin
      frame_q <= frame_mem[sp_m2[VW-1:0]];
    end
    if (push_edge && etop_r < CW'(ME)) begin
      edge_mem[etop_r[EW-1:0]] <= {cu_r, push_to};
    end
    if (cmd.op == bcc_pkg::OP_CMP_RD) begin
      edge_q <= edge_mem[EW'(etop_r - CW'(1))];
    end
    if ((cmd.op == bcc_pkg::OP_CMP_A || cmd.op == bcc_pkg::OP_CMP_B) && add_ok) begin
      res_mem[rcnt_r[RW-1:0]] <= {comp_r, cmp_x, 1'b0};
    end else if (cmd.op == bcc_pkg::OP_CMP_FIN && rcnt_r != start_r) begin
      res_mem[rcnt_m1[RW-1:0]] <= {comp_r, lastv_r, 1'b1};
    end
    if (cmd.op == bcc_pkg::OP_FETCH) begin
      res_q <= res_mem[pos_r[RW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= bcc_pkg::VCOUNT_RESET;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      phase_r     <= 1'b0;
      head_vld_r  <= '0;
      visited_r   <= '0;
      seen_r      <= '0;
      rcnt_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      etop_r      <= '0;
      sp_r        <= '0;
    end else begin
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (push_edge && etop_r < CW'(ME)) begin
        etop_r <= etop_r + CW'(1);
      end
      unique case (cmd.op)
        bcc_pkg::OP_TAKE: begin
        end
        bcc_pkg::OP_APP_WR: begin
          if (!app_ok) begin
            ovf_r <= 1'b1;
          end
        end
        bcc_pkg::OP_APP_LINK: begin
          head_vld_r[fv_idx] <= 1'b1;
          cnt_r <= cnt_r + CW'(1);
        end
        bcc_pkg::OP_SRCH_INIT: begin
          visited_r <= '0;
          etop_r    <= '0;
          rcnt_r    <= '0;
          sp_r      <= '0;
        end
        bcc_pkg::OP_ROOT: begin
          if (root_r >= n_r) begin
            phase_r <= 1'b1;
            pos_r   <= '0;
          end
        end
        bcc_pkg::OP_OPEN: begin
          visited_r[v_r] <= 1'b1;
          sp_r <= sp_r + SW'(1);
        end
        bcc_pkg::OP_EDGE: begin
          if (ce_r[EW]) begin
            sp_r <= sp_r - SW'(1);
          end
        end
        bcc_pkg::OP_NBR, bcc_pkg::OP_BACK: begin
        end
        bcc_pkg::OP_POP_RET: begin
          if (chlow_r >= f_disc) begin
            seen_r <= '0;
          end
        end
        bcc_pkg::OP_CMP_RD: begin
          if (etop_r != '0) begin
            etop_r <= etop_r - CW'(1);
          end
        end
        bcc_pkg::OP_CMP_A, bcc_pkg::OP_CMP_B: begin
          if (add_ok) begin
            seen_r[cmp_x] <= 1'b1;
            rcnt_r <= rcnt_r + RCW'(1);
          end
        end
        bcc_pkg::OP_CMP_FIN: begin
        end
        bcc_pkg::OP_FETCH: begin
          if (pos_r >= rcnt_r) begin
            out_valid_r <= 1'b1;
          end
        end
        bcc_pkg::OP_FETCH_OUT: begin
          out_valid_r <= 1'b1;
          if (!fo_last) begin
            pos_r <= pos_p1;
          end
        end
        default: begin
        end
      endcase
      if (clear) begin
        cnt_r      <= '0;
        head_vld_r <= '0;
        ovf_r      <= 1'b0;
        phase_r    <= 1'b0;
        rcnt_r     <= '0;
        pos_r      <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bcc_pkg::OP_TAKE: begin
        if (in_fire) begin
          from_r <= in_chan.from_vertex;
          to_r   <= in_chan.to_vertex;
        end
      end
      bcc_pkg::OP_SRCH_INIT: begin
        n_r     <= n_cur;
        root_r  <= '0;
        timer_r <= '0;
        comp_r  <= '0;
      end
      bcc_pkg::OP_ROOT: begin
        if (root_r < n_r) begin
          if (visited_r[root_r[VW-1:0]]) begin
            root_r <= root_r + NW'(1);
          end else begin
            v_r   <= root_r[VW-1:0];
            par_r <= '0;
          end
        end
      end
      bcc_pkg::OP_OPEN: begin
        cu_r    <= v_r;
        cp_r    <= par_r;
        ce_r    <= head_vq ? {1'b0, head_q} : LNK_NONE;
        clow_r  <= timer_r;
        cdisc_r <= timer_r;
        timer_r <= timer_r + VW'(1);
      end
      bcc_pkg::OP_EDGE: begin
        if (ce_r[EW]) begin
          if (sp_r == SW'(1)) begin
            root_r <= root_r + NW'(1);
          end else begin
            child_r <= cu_r;
            chlow_r <= clow_r;
          end
        end
      end
      bcc_pkg::OP_NBR: begin
        if (nbr_skip || visited_r[nbr_q]) begin
          ce_r <= link_q;
        end else begin
          v_r   <= nbr_q;
          par_r <= cu_r;
        end
      end
      bcc_pkg::OP_BACK: begin
        if (disc_q < cdisc_r && disc_q < clow_r) begin
          clow_r <= disc_q;
        end
      end
      bcc_pkg::OP_POP_RET: begin
        cu_r    <= f_v;
        cp_r    <= f_p;
        ce_r    <= f_next;
        cdisc_r <= f_disc;
        clow_r  <= (chlow_r < f_low) ? chlow_r : f_low;
        cmp_u_r <= f_v;
        cmp_c_r <= child_r;
        start_r <= rcnt_r;
      end
      bcc_pkg::OP_CMP_A, bcc_pkg::OP_CMP_B: begin
        if (add_ok) begin
          lastv_r <= cmp_x;
        end
      end
      bcc_pkg::OP_CMP_FIN: begin
        comp_r <= comp_r + bcc_pkg::COMP_W'(1);
      end
      bcc_pkg::OP_FETCH: begin
        o_has_r  <= 1'b0;
        o_comp_r <= '0;
        o_vert_r <= '0;
        o_lic_r  <= 1'b0;
        o_lov_r  <= 1'b1;
        o_ovf_r  <= ovf_r;
      end
      bcc_pkg::OP_FETCH_OUT: begin
        o_has_r  <= 1'b1;
        o_comp_r <= res_q[XW-1:VW+1];
        o_vert_r <= bcc_pkg::VID_W'(res_q[VW:1]);
        o_lic_r  <= res_q[0];
        o_lov_r  <= fo_last;
        o_ovf_r  <= ovf_r;
      end
      default: begin
      end
    endcase
  end

  assign in_chan.ready              = cmd.in_ready;
  assign out_chan.valid             = out_valid_r;
  assign out_chan.has_pair          = o_has_r;
  assign out_chan.component_index   = o_comp_r;
  assign out_chan.member_vertex     = o_vert_r;
  assign out_chan.last_in_component = o_lic_r;
  assign out_chan.last_overall      = o_lov_r;
  assign out_chan.overflow          = o_ovf_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SW'(MV))
    else $error("call stack beyond vertex count");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ME))
    else $error("entry count beyond capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> pos_r <= rcnt_r)
    else $error("result pointer past result count");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == bcc_pkg::OP_FETCH_OUT && fo_last) |=> (!phase_r && cnt_r == '0))
    else $error("graph not cleared after final pair");

endmodule
